// ===== hdl/pse_pkg.sv =====
package pse_pkg;

   // geometry
   localparam int STACK_DEPTH   = 16;
   localparam int FRACTION_BITS = 16;
   localparam int WORD_W        = 48;
   localparam int OPC_W         = 3;
   localparam int NUM_W         = 31;
   localparam int STATUS_W      = 3;
   localparam int DEPTH_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W        = $clog2(STACK_DEPTH);

   // multiplier: WORD_W x CHUNK_W per cycle, MSB chunk first
   localparam int CHUNK_W   = 16;
   localparam int MUL_STEPS = WORD_W / CHUNK_W;
   localparam int PROD_W    = 2 * WORD_W;

   // divider: one quotient bit per cycle over the scaled dividend
   localparam int DIV_STEPS = WORD_W + FRACTION_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // width for magnitudes ahead of the final clamp
   localparam int WIDE_W = 2 * WORD_W;

   localparam logic [WORD_W-1:0] POS_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] NEG_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // opcodes
   localparam logic [OPC_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OPC_W-1:0] OP_ADD  = 3'd1;
   localparam logic [OPC_W-1:0] OP_SUB  = 3'd2;
   localparam logic [OPC_W-1:0] OP_MUL  = 3'd3;
   localparam logic [OPC_W-1:0] OP_DIV  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd5;

   typedef enum logic [2:0] {
      SEL_ADD,
      SEL_SUB,
      SEL_MUL,
      SEL_DIV,
      SEL_ZERO
   } res_sel_type;

   typedef struct packed {
      logic                tok_load;
      logic                push;
      logic                rd_en;
      logic                op_load;
      logic                mul_step;
      logic                div_step;
      logic                commit;
      res_sel_type         sel;
      logic                err_valid;
      logic [STATUS_W-1:0] err_code;
      logic                emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OPC_W-1:0] opcode;
      logic             last;
      logic             depth_zero;
      logic             depth_full;
      logic             depth_lt2;
      logic             second_zero;
   } dp_status_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              sat;
   } clamp_type;

   function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] x);
      magnitude = x[WORD_W-1] ? (~x + WORD_W'(1)) : x;
   endfunction

   // sign plus magnitude to a word, clamped to the signed range
   function automatic clamp_type clamp_mag(input logic neg, input logic [WIDE_W-1:0] mag);
      clamp_type r;
      r.sat = 1'b0;
      if (neg) begin
         if (mag > WIDE_W'(NEG_MIN)) begin
            r.sat   = 1'b1;
            r.value = NEG_MIN;
         end else begin
            r.value = ~mag[WORD_W-1:0] + WORD_W'(1);
         end
      end else begin
         if (mag > WIDE_W'(POS_MAX)) begin
            r.sat   = 1'b1;
            r.value = POS_MAX;
         end else begin
            r.value = mag[WORD_W-1:0];
         end
      end
      return r;
   endfunction

endpackage

// ===== hdl/postfix_stack_evaluator.sv =====
// channel | direction | words                                  | handshake
// req     | in        | opcode, number_value, last_token       | req_valid / req_stall
// rsp     | out       | result_value (Q32.16), status          | rsp_valid / rsp_stall
//
// One word in flight at a time: push and ignored opcodes dispatch and finish;
// operators read operands and commit: multiply with three 48x16 products, divide
// one quotient bit per cycle over 64 dividend bits in the shift-subtract unit.
// Synchronous active-high reset empties the stack and clears the error; the
// stack memory itself is not cleared, entries are only read after a push.
// The response sits in an output register; a stalled response only holds
// off the next word that ends an expression.
module postfix_stack_evaluator (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pse_pkg::OPC_W-1:0]           req_opcode,
   input  logic [pse_pkg::NUM_W-1:0]           req_number_value,
   input  logic                                req_last_token,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pse_pkg::WORD_W-1:0]   rsp_result_value,
   output logic [pse_pkg::STATUS_W-1:0]        rsp_status
);
   import pse_pkg::*;

   // controller to datapath commands, datapath flags back
   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // sequencer: accept, dispatch, operand read, iterate, commit, emit
   pse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stack, multiplier, divider, sticky error and the response register
   pse_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_number_value (req_number_value),
      .req_last_token   (req_last_token),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== hdl/pse_ram.sv =====
module pse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pse_ctrl.sv =====
module pse_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  pse_pkg::dp_status_type sts,
   output pse_pkg::ctrl_cmd_type  cmd
);
   import pse_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_READ,
      S_MUL,
      S_DIV,
      S_COMMIT,
      S_FINISH
   } state_type;

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   res_sel_type sel_ff, sel_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      cmd.sel      = sel_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.tok_load = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            case (sts.opcode) inside
               OP_PUSH: begin
                  if (sts.depth_full) begin
                     cmd.err_valid = 1'b1;
                     cmd.err_code  = ST_OVERFLOW;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (sts.depth_lt2) begin
                     cmd.err_valid = 1'b1;
                     cmd.err_code  = ST_UNDERFLOW;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_READ;
                  end
               end
               default: begin
                  // unused opcodes do nothing
               end
            endcase
         end
         S_READ: begin
            cmd.op_load = 1'b1;
            cnt_in      = '0;
            case (sts.opcode)
               OP_ADD: begin
                  sel_in   = SEL_ADD;
                  state_in = S_COMMIT;
               end
               OP_SUB: begin
                  sel_in   = SEL_SUB;
                  state_in = S_COMMIT;
               end
               OP_MUL: begin
                  sel_in   = SEL_MUL;
                  state_in = S_MUL;
               end
               default: begin
                  if (sts.second_zero) begin
                     cmd.err_valid = 1'b1;
                     cmd.err_code  = ST_DIVZERO;
                     sel_in        = SEL_ZERO;
                     state_in      = S_COMMIT;
                  end else begin
                     sel_in   = SEL_DIV;
                     state_in = S_DIV;
                  end
               end
            endcase
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = S_COMMIT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!sts.last) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sel_ff       <= SEL_ADD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/pse_dp.sv =====
module pse_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [pse_pkg::OPC_W-1:0]              req_opcode,
   input  logic [pse_pkg::NUM_W-1:0]              req_number_value,
   input  logic                                   req_last_token,
   input  pse_pkg::ctrl_cmd_type                  cmd,
   output pse_pkg::dp_status_type                 sts,
   output logic signed [pse_pkg::WORD_W-1:0]      rsp_result_value,
   output logic [pse_pkg::STATUS_W-1:0]           rsp_status
);
   import pse_pkg::*;

   // latched word
   logic [OPC_W-1:0]    tok_op_ff;
   logic [NUM_W-1:0]    tok_num_ff;
   logic                tok_last_ff;

   // stack: top in a register, the rest in RAM at 0 .. depth-2
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [WORD_W-1:0]   tos_ff, tos_in;
   logic [STATUS_W-1:0] err_ff, err_in;

   // operands and arithmetic
   logic [WORD_W-1:0]    opa_ff;
   logic [WORD_W-1:0]    mag_a_ff, mag_b_ff, mag_b_in;
   logic                 neg_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0]    rem_ff, rem_in;

   logic [WORD_W-1:0]   out_value_ff;
   logic [STATUS_W-1:0] out_status_ff;

   logic [WORD_W-1:0]   ram_rdata;
   logic [DEPTH_W-1:0]  depth_m1, depth_m2;
   logic                ram_wr_en;

   logic [CHUNK_W+WORD_W-1:0] pp;
   logic [WORD_W:0]           rem_sh;
   logic [WORD_W:0]           sum;
   logic [WORD_W:0]           sum_mag;
   clamp_type                 push_res, op_res;
   logic                      rec_valid;
   logic [STATUS_W-1:0]       rec_code;

   assign depth_m1  = depth_ff - DEPTH_W'(1);
   assign depth_m2  = depth_ff - DEPTH_W'(2);
   assign ram_wr_en = cmd.push & (depth_ff != '0);

   pse_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (depth_m1[ADDR_W-1:0]),
      .wr_data (tos_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (depth_m2[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // multiply step: partial product of the top chunk of b
   assign pp      = mag_a_ff * mag_b_ff[WORD_W-1 -: CHUNK_W];
   assign prod_in = (prod_ff << CHUNK_W) + PROD_W'(pp);
   assign mag_b_in = mag_b_ff << CHUNK_W;

   // restoring divide step
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_STEPS-1]};
      if (rem_sh >= {1'b0, mag_b_ff}) begin
         rem_in = WORD_W'(rem_sh - {1'b0, mag_b_ff});
         quo_in = {quo_ff[DIV_STEPS-2:0], 1'b1};
      end else begin
         rem_in = rem_sh[WORD_W-1:0];
         quo_in = {quo_ff[DIV_STEPS-2:0], 1'b0};
      end
   end

   assign push_res = clamp_mag(1'b0, WIDE_W'(tok_num_ff) << FRACTION_BITS);

   // result select and clamp
   always_comb begin
      if (tok_op_ff == OP_SUB) begin
         sum = {opa_ff[WORD_W-1], opa_ff} - {tos_ff[WORD_W-1], tos_ff};
      end else begin
         sum = {opa_ff[WORD_W-1], opa_ff} + {tos_ff[WORD_W-1], tos_ff};
      end
      sum_mag = sum[WORD_W] ? (~sum + (WORD_W+1)'(1)) : sum;
      case (cmd.sel) inside
         SEL_ADD, SEL_SUB: op_res = clamp_mag(sum[WORD_W], WIDE_W'(sum_mag));
         SEL_MUL:          op_res = clamp_mag(neg_ff, WIDE_W'(prod_ff >> FRACTION_BITS));
         SEL_DIV:          op_res = clamp_mag(neg_ff, WIDE_W'(quo_ff));
         default:          op_res = '{value: '0, sat: 1'b0};
      endcase
   end

   always_comb begin
      depth_in  = depth_ff;
      tos_in    = tos_ff;
      rec_valid = cmd.err_valid;
      rec_code  = cmd.err_code;
      if (cmd.push) begin
         tos_in   = push_res.value;
         depth_in = depth_ff + DEPTH_W'(1);
         if (push_res.sat) begin
            rec_valid = 1'b1;
            rec_code  = ST_SATURATED;
         end
      end
      if (cmd.commit) begin
         tos_in   = op_res.value;
         depth_in = depth_m1;
         if (op_res.sat) begin
            rec_valid = 1'b1;
            rec_code  = ST_SATURATED;
         end
      end
      if (cmd.emit) begin
         depth_in = '0;
         err_in   = '0;
      end else if (err_ff == ST_OK && rec_valid) begin
         err_in = rec_code;
      end else begin
         err_in = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         err_ff   <= ST_OK;
      end else begin
         depth_ff <= depth_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      if (cmd.tok_load) begin
         tok_op_ff   <= req_opcode;
         tok_num_ff  <= req_number_value;
         tok_last_ff <= req_last_token;
      end
      if (cmd.op_load) begin
         opa_ff   <= ram_rdata;
         mag_a_ff <= magnitude(ram_rdata);
         mag_b_ff <= magnitude(tos_ff);
         neg_ff   <= ram_rdata[WORD_W-1] ^ tos_ff[WORD_W-1];
         prod_ff  <= '0;
         quo_ff   <= DIV_STEPS'(magnitude(ram_rdata)) << FRACTION_BITS;
         rem_ff   <= '0;
      end
      if (cmd.mul_step) begin
         prod_ff  <= prod_in;
         mag_b_ff <= mag_b_in;
      end
      if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.emit) begin
         if (depth_ff == '0) begin
            out_value_ff  <= '0;
            out_status_ff <= (err_ff != ST_OK) ? err_ff : ST_EMPTY;
         end else begin
            out_value_ff  <= tos_ff;
            out_status_ff <= err_ff;
         end
      end
   end

   assign sts.opcode      = tok_op_ff;
   assign sts.last        = tok_last_ff;
   assign sts.depth_zero  = (depth_ff == '0);
   assign sts.depth_full  = (depth_ff == DEPTH_W'(STACK_DEPTH));
   assign sts.depth_lt2   = (depth_ff < DEPTH_W'(2));
   assign sts.second_zero = (tos_ff == '0);

   assign rsp_result_value = $signed(out_value_ff);
   assign rsp_status       = out_status_ff;

endmodule
